@@ rtl/core/qebi_pkg.sv @@
// ----------------------------------------------------------------------------
// qebi_pkg: shared types and constants
// Event bit positions, register indexes, item kinds and the quadrature
// transition table of the encoder and button input block.
// ----------------------------------------------------------------------------
package qebi_pkg;

    // Item kinds carried on the input stream tuser.
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_STEPS      = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0]  DEBOUNCE_RST   = 8'd5;
    localparam logic [15:0] LONG_PRESS_RST = 16'd500;
    localparam logic [1:0]  STEPS_RST      = 2'd2;

    // Event set bits.
    localparam logic [3:0] EVT_CW    = 4'b0001;
    localparam logic [3:0] EVT_CCW   = 4'b0010;
    localparam logic [3:0] EVT_SHORT = 4'b0100;
    localparam logic [3:0] EVT_LONG  = 4'b1000;

    // Both encoder pins idle high.
    localparam logic [1:0] PINS_IDLE = 2'b11;

    // Button press events from the debounce unit.
    typedef struct packed {
        logic long_press;
        logic short_press;
    } btn_evt_t;

    // Quadrature step for a move from the previous to the current pin pair.
    // Returns +1, -1 or 0 (no move or an illegal double jump).
    function automatic logic signed [1:0] quad_step(input logic [1:0] prev_pins,
                                                    input logic [1:0] pins);
        logic [3:0] code;
        logic signed [1:0] step;
        code = {prev_pins, pins};
        unique case (code)
            4'd1, 4'd7, 4'd8, 4'd14: step = 2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = -2'sd1;
            default: step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage

@@ rtl/core/qebi_button.sv @@
// ----------------------------------------------------------------------------
// qebi_button: button debounce and press classification
// Holds the debounce state of the active-low button; reports a long press
// once the hold time is reached, else a short press on a settled release.
// ----------------------------------------------------------------------------
module qebi_button (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  logic                btn,
    input  logic [31:0]         now_ms,
    input  logic [7:0]          debounce_ms,
    input  logic [15:0]         long_press_ms,
    output qebi_pkg::btn_evt_t  evt
);

    logic        raw_reg, raw_next;
    logic        stable_reg, stable_next;
    logic [31:0] change_reg, change_next;
    logic [31:0] press_reg, press_next;
    logic        long_done_reg, long_done_next;
    logic [31:0] settle_age;
    logic [31:0] hold_age;

    // Debounce the raw level, then classify the press.
    always_comb
    begin
        raw_next       = btn;
        change_next    = (btn != raw_reg) ? now_ms : change_reg;
        stable_next    = stable_reg;
        press_next     = press_reg;
        long_done_next = long_done_reg;
        evt            = '0;

        settle_age = now_ms - change_next;
        if ((settle_age >= {24'd0, debounce_ms}) && (stable_reg != raw_next))
        begin
            stable_next = raw_next;
            if (!raw_next)
            begin
                press_next     = now_ms;
                long_done_next = 1'b0;
            end
            else if (!long_done_reg)
            begin
                evt.short_press = 1'b1;
            end
        end

        hold_age = now_ms - press_next;
        if (!stable_next && !long_done_next && (hold_age >= {16'd0, long_press_ms}))
        begin
            long_done_next = 1'b1;
            evt.long_press = 1'b1;
        end
    end

    // Button state advances only on a poll.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg       <= 1'b1;
            stable_reg    <= 1'b1;
            change_reg    <= '0;
            press_reg     <= '0;
            long_done_reg <= 1'b0;
        end
        else if (update)
        begin
            raw_reg       <= raw_next;
            stable_reg    <= stable_next;
            change_reg    <= change_next;
            press_reg     <= press_next;
            long_done_reg <= long_done_next;
        end
    end

endmodule

@@ rtl/core/quadrature_encoder_button_input.sv @@
// ----------------------------------------------------------------------------
// quadrature_encoder_button_input: encoder decoder with button debounce
// Decodes quadrature edges into detent counts and debounces a push button,
// returning one result per encoder edge or poll item.
// ----------------------------------------------------------------------------
// The block accepts one item in every cycle while results are taken, and
// returns one result per item: the item is captured in an input
// register, and one pass of table lookup, step accumulation and debounce
// compares writes the result register and the state. A full result register
// that is not taken stalls the input only once the input register is full as
// well. Configuration writes are taken at any time and should be made while
// no item is in flight.
module quadrature_encoder_button_input (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: enc_pins[1:0], button_level[2], now_ms[34:3], zero fill
    input  logic [39:0] s_tdata,
    // tuser: op (0 = encoder edge, 1 = poll)
    input  logic        s_tuser,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: evt_cw[0], evt_ccw[1], evt_short[2], evt_long[3],
    // position[35:4], recent_events[39:36], event_total[71:40]
    output logic [71:0] m_tdata,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    logic [7:0]  debounce_reg;
    logic [15:0] long_press_reg;
    logic [1:0]  steps_reg;

    // Input register.
    logic        in_valid_reg;
    logic        in_op_reg;
    logic [1:0]  in_pins_reg;
    logic        in_btn_reg;
    logic [31:0] in_now_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_op_reg;
    logic [3:0]  out_evt_reg;

    // Decoder and event state.
    logic [1:0]        prev_pins_reg, prev_pins_next;
    logic signed [2:0] accum_reg, accum_next;
    logic [31:0]       position_reg, position_next;
    logic [3:0]        pending_reg, pending_next;
    logic [3:0]        last_reg, last_next;
    logic [31:0]       count_reg, count_next;
    logic [3:0]        evt_next;

    logic              advance;
    logic              poll_update;
    logic signed [1:0] step;
    logic signed [2:0] sum;
    logic signed [2:0] th_pos;
    logic signed [2:0] th_neg;
    logic [3:0]        edge_set;
    logic [3:0]        btn_set;
    qebi_pkg::btn_evt_t btn_evt;

    // Handshake: the input register moves on when the result register frees.
    assign advance     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !in_valid_reg || advance;
    assign cfg_ready   = 1'b1;
    assign poll_update = advance && (in_op_reg == qebi_pkg::OP_POLL);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= qebi_pkg::DEBOUNCE_RST;
            long_press_reg <= qebi_pkg::LONG_PRESS_RST;
            steps_reg      <= qebi_pkg::STEPS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                qebi_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data[7:0];
                qebi_pkg::REG_LONG_PRESS: long_press_reg <= cfg_data;
                qebi_pkg::REG_STEPS:      steps_reg      <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Input register capture on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_pins_reg <= s_tdata[1:0];
            in_btn_reg  <= s_tdata[2];
            in_now_reg  <= s_tdata[34:3];
        end
    end

    // Button debounce unit.
    qebi_button u_button (
        .clk           (clk),
        .rst_n         (rst_n),
        .update        (poll_update),
        .btn           (in_btn_reg),
        .now_ms        (in_now_reg),
        .debounce_ms   (debounce_reg),
        .long_press_ms (long_press_reg),
        .evt           (btn_evt)
    );

    // Step accumulation thresholds; a count of zero acts as one.
    assign step   = qebi_pkg::quad_step(prev_pins_reg, in_pins_reg);
    assign sum    = accum_reg + {step[1], step};
    assign th_pos = $signed({1'b0, steps_reg});
    assign th_neg = -th_pos;

    assign btn_set = (btn_evt.short_press ? qebi_pkg::EVT_SHORT : 4'd0)
                   | (btn_evt.long_press  ? qebi_pkg::EVT_LONG  : 4'd0);

    // One pass over the item: encoder decode or poll event gathering.
    always_comb
    begin
        prev_pins_next = prev_pins_reg;
        accum_next     = accum_reg;
        position_next  = position_reg;
        pending_next   = pending_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        evt_next       = '0;
        edge_set       = '0;

        if (in_op_reg == qebi_pkg::OP_EDGE)
        begin
            if (in_pins_reg != prev_pins_reg)
            begin
                prev_pins_next = in_pins_reg;
                priority if (step == 2'sd0)
                begin
                    accum_next = '0;
                end
                else if (sum >= th_pos)
                begin
                    accum_next    = '0;
                    position_next = position_reg + 32'd1;
                    edge_set      = qebi_pkg::EVT_CW;
                end
                else if (sum <= th_neg)
                begin
                    accum_next    = '0;
                    position_next = position_reg - 32'd1;
                    edge_set      = qebi_pkg::EVT_CCW;
                end
                else
                begin
                    accum_next = sum;
                end
            end
            if (edge_set != 4'd0)
            begin
                pending_next = pending_reg | edge_set;
                last_next    = edge_set;
                count_next   = count_reg + 32'd1;
            end
        end
        else
        begin
            evt_next     = btn_set | pending_reg;
            pending_next = '0;
            if (btn_set != 4'd0)
            begin
                last_next  = evt_next;
                count_next = count_reg + 32'd1;
            end
        end
    end

    // State update and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= qebi_pkg::PINS_IDLE;
            accum_reg     <= '0;
            position_reg  <= '0;
            pending_reg   <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                prev_pins_reg <= prev_pins_next;
                accum_reg     <= accum_next;
                position_reg  <= position_next;
                pending_reg   <= pending_next;
                last_reg      <= last_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_evt_reg <= evt_next;
            out_op_reg  <= in_op_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {count_reg, last_reg, position_reg, out_evt_reg};

    // The accumulator rests strictly inside the largest detent threshold.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accum_reg >= -3'sd2) && (accum_reg <= 3'sd2))
        else $error("step accumulator out of range");

    // An encoder edge result never carries poll events.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_op_reg == qebi_pkg::OP_EDGE)) |-> (out_evt_reg == 4'd0))
        else $error("edge result carries events");

    // The event count grows by at most one per item and holds otherwise.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> ((count_reg == $past(count_reg)) ||
                     (count_reg == $past(count_reg) + 32'd1)))
        else $error("event count jumped");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(count_reg))
        else $error("event count changed without an item");

    // A position step is always counted as an event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (position_next != position_reg)) |-> (count_next == count_reg + 32'd1))
        else $error("position moved without an event");

endmodule

@@ bench/quadrature_encoder_button_input_test.sv @@
// ----------------------------------------------------------------------------
// quadrature_encoder_button_input_test: self-checking bench for the encoder
// and button input block
// A bit-accurate predictor of the quadrature decoder and the button debounce
// runs beside the block. Every accepted item is predicted at its transfer and
// every result transfer is compared field by field with the oldest prediction.
// Stimulus is a short directed set, then realistic encoder turns and button
// presses under several register settings, output backpressure, timestamp
// wrap-around and random noise, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module quadrature_encoder_button_input_test;

    localparam int RUN_LIMIT    = 400000;
    localparam int REPORT_LIMIT = 10;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Button pin levels (active low).
    localparam logic BTN_PRESSED  = 1'b0;
    localparam logic BTN_RELEASED = 1'b1;

    typedef enum {TX_STEADY, TX_BURSTY} tx_mode_t;
    typedef enum {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_t;
    typedef enum {TURN_CW, TURN_CCW, TURN_JUMP, TURN_HOLD} turn_t;

    // One input item as seen on the input stream.
    typedef struct packed {
        logic        op;
        logic [1:0]  pins;
        logic        btn;
        logic [31:0] now;
    } sample_t;

    // One result item as seen on the result stream.
    typedef struct packed {
        logic [3:0]         evts;
        logic signed [31:0] position;
        logic [3:0]         recent;
        logic [31:0]        total;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Predictor configuration and state.
    logic [7:0]  reg_debounce_ms;
    logic [15:0] reg_long_ms;
    logic [1:0]  reg_steps;
    logic [1:0]  pins_last;
    int          quad_acc;
    logic [31:0] detent_pos;
    logic [3:0]  pend_set;
    logic [3:0]  shown_set;
    logic [31:0] set_count;
    logic        btn_raw;
    logic        btn_settled;
    logic [31:0] btn_change_ms;
    logic [31:0] btn_press_ms;
    logic        long_fired;

    report_t expected_reports[$];

    // Run statistics and failures.
    int mismatches = 0;
    int results_seen = 0;
    int edges_in = 0;
    int polls_in = 0;
    int cw_seen = 0;
    int ccw_seen = 0;
    int short_seen = 0;
    int long_seen = 0;
    int reg_writes = 0;
    int cycle_count = 0;
    int longest_hold = 0;

    // Sender side: idle pattern, encoder walk and button script.
    tx_mode_t    tx_mode = TX_STEADY;
    int          burst_left = 0;
    logic [1:0]  walk_pins = qebi_pkg::PINS_IDLE;
    logic        walk_cw = 1'b1;
    logic [31:0] clock_ms = 32'd0;
    logic        btn_drive = BTN_RELEASED;
    logic [31:0] btn_next_ms = 32'd50;
    logic [31:0] btn_last_ms = 32'd0;

    // Receiver side: stall pattern and long hold request.
    rx_mode_t    rx_mode = RX_ALWAYS;
    logic [15:0] rx_pattern = 16'hB5A7;
    logic [3:0]  rx_phase = '0;
    int          rx_hold_req = 0;
    int          rx_hold_left = 0;

    quadrature_encoder_button_input DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of 4 time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Reset values of the registers and the decoder state.
    task automatic reset_predictor();
        reg_debounce_ms = 8'd5;
        reg_long_ms     = 16'd500;
        reg_steps       = 2'd2;
        pins_last       = qebi_pkg::PINS_IDLE;
        quad_acc        = 0;
        detent_pos      = '0;
        pend_set        = '0;
        shown_set       = '0;
        set_count       = '0;
        btn_raw         = BTN_RELEASED;
        btn_settled     = BTN_RELEASED;
        btn_change_ms   = '0;
        btn_press_ms    = '0;
        long_fired      = 1'b0;
    endtask

    // Quadrature move for a {previous, current} pin code: +1, -1, or 0 for
    // no move and for a jump over both pins.
    function automatic int quad_move(input logic [3:0] code);
        int move;
        case (code)
            4'h1, 4'h7, 4'h8, 4'hE: move = 1;
            4'h2, 4'h4, 4'hB, 4'hD: move = -1;
            default:                move = 0;
        endcase
        return move;
    endfunction

    // Applies one item to the predictor state and returns the result it gives.
    function automatic report_t decode_item(input sample_t s);
        report_t    r;
        logic [3:0] ev;
        logic [3:0] hit;
        logic [31:0] held;
        int         move;
        int         limit;
        ev  = '0;
        hit = '0;
        if (s.op == qebi_pkg::OP_EDGE)
        begin
            edges_in++;
            if (s.pins != pins_last)
            begin
                move = quad_move({pins_last, s.pins});
                pins_last = s.pins;
                if (move == 0)
                begin
                    quad_acc = 0;
                end
                else
                begin
                    // A threshold of zero acts as one: any legal move counts.
                    limit = int'(reg_steps);
                    quad_acc += move;
                    if (quad_acc >= limit)
                    begin
                        quad_acc = 0;
                        detent_pos += 32'd1;
                        hit = qebi_pkg::EVT_CW;
                        cw_seen++;
                    end
                    else if (quad_acc <= -limit)
                    begin
                        quad_acc = 0;
                        detent_pos -= 32'd1;
                        hit = qebi_pkg::EVT_CCW;
                        ccw_seen++;
                    end
                    // A detent is recorded at once and held for the next poll.
                    if (hit != '0)
                    begin
                        pend_set  |= hit;
                        shown_set  = hit;
                        set_count += 32'd1;
                    end
                end
            end
        end
        else
        begin
            polls_in++;
            // Debounce: the raw level must stay put for the settle time.
            if (s.btn != btn_raw)
            begin
                btn_raw = s.btn;
                btn_change_ms = s.now;
            end
            held = s.now - btn_change_ms;
            if (held >= 32'(reg_debounce_ms) && btn_settled != btn_raw)
            begin
                btn_settled = btn_raw;
                if (btn_settled == BTN_PRESSED)
                begin
                    btn_press_ms = s.now;
                    long_fired = 1'b0;
                end
                else if (!long_fired)
                begin
                    ev |= qebi_pkg::EVT_SHORT;
                end
            end
            // Long press fires once per press while the button is held.
            held = s.now - btn_press_ms;
            if (btn_settled == BTN_PRESSED && !long_fired && held >= 32'(reg_long_ms))
            begin
                long_fired = 1'b1;
                ev |= qebi_pkg::EVT_LONG;
            end
            ev |= pend_set;
            pend_set = '0;
            if ((ev & (qebi_pkg::EVT_SHORT | qebi_pkg::EVT_LONG)) != '0)
            begin
                shown_set = ev;
                set_count += 32'd1;
            end
            if ((ev & qebi_pkg::EVT_SHORT) != '0)
                short_seen++;
            if ((ev & qebi_pkg::EVT_LONG) != '0)
                long_seen++;
        end
        r.evts     = ev;
        r.position = detent_pos;
        r.recent   = shown_set;
        r.total    = set_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
        end
    endfunction

    // Result transfers are checked first, then input transfers are predicted,
    // so a result can never be matched against an item taken in the same cycle.
    always @(posedge clk)
    begin
        sample_t s;
        report_t want;
        report_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.evts     = m_tdata[3:0];
            got.position = m_tdata[35:4];
            got.recent   = m_tdata[39:36];
            got.total    = m_tdata[71:40];
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d: transfer with no item outstanding, data 0x%0h",
                             results_seen, m_tdata);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("evt_cw", 32'(want.evts[0]), 32'(got.evts[0]));
                check_field("evt_ccw", 32'(want.evts[1]), 32'(got.evts[1]));
                check_field("evt_short", 32'(want.evts[2]), 32'(got.evts[2]));
                check_field("evt_long", 32'(want.evts[3]), 32'(got.evts[3]));
                check_field("position", want.position, got.position);
                check_field("recent_events", 32'(want.recent), 32'(got.recent));
                check_field("event_total", want.total, got.total);
            end
            results_seen++;
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            s.op   = s_tuser;
            s.pins = s_tdata[1:0];
            s.btn  = s_tdata[2];
            s.now  = s_tdata[34:3];
            expected_reports.push_back(decode_item(s));
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern plus an occasional long hold
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
            if (rx_hold_left > longest_hold)
                longest_hold = rx_hold_left;
        end
        if (rx_hold_left != 0)
        begin
            m_tready = 1'b0;
            rx_hold_left--;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:
                    m_tready = 1'b1;
                RX_PATTERN:
                begin
                    m_tready = rx_pattern[rx_phase];
                    rx_phase = rx_phase + 4'd1;
                    if (rx_phase == 4'd0)
                        rx_pattern = 16'($urandom) | 16'h0001;
                end
                default:
                    m_tready = ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("quadrature_encoder_button_input: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one item and returns at the clock edge of its transfer.
    task automatic send_item(input logic op, input logic [1:0] pins, input logic btn,
                             input logic [31:0] now);
        int gap;
        @(negedge clk);
        if (tx_mode == TX_BURSTY)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(1, 8);
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left--;
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {5'b0, now, btn, pins};
        if (op == qebi_pkg::OP_EDGE)
            walk_pins = pins;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops offering and waits until every outstanding result has arrived.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, made only while the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        settle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            qebi_pkg::REG_DEBOUNCE:   reg_debounce_ms = value[7:0];
            qebi_pkg::REG_LONG_PRESS: reg_long_ms = value;
            qebi_pkg::REG_STEPS:      reg_steps = value[1:0];
            default:                  ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
        @(posedge clk);
    endtask

    // Writes all three registers; unused upper data bits carry random values.
    task automatic apply_settings(input int debounce, input int hold, input int steps);
        logic [15:0] value;
        value = 16'($urandom);
        value[7:0] = 8'(debounce);
        write_reg(qebi_pkg::REG_DEBOUNCE, value);
        write_reg(qebi_pkg::REG_LONG_PRESS, 16'(hold));
        value = 16'($urandom);
        value[1:0] = 2'(steps);
        write_reg(qebi_pkg::REG_STEPS, value);
    endtask

    // Next pin pair of the encoder for one kind of move.
    function automatic logic [1:0] turn_pins(input logic [1:0] cur, input turn_t how);
        logic [1:0] nxt;
        case (how)
            TURN_CW:
                case (cur)
                    2'b11:   nxt = 2'b10;
                    2'b10:   nxt = 2'b00;
                    2'b00:   nxt = 2'b01;
                    default: nxt = 2'b11;
                endcase
            TURN_CCW:
                case (cur)
                    2'b11:   nxt = 2'b01;
                    2'b01:   nxt = 2'b00;
                    2'b00:   nxt = 2'b10;
                    default: nxt = 2'b11;
                endcase
            TURN_JUMP:
                nxt = cur ^ 2'b11;
            default:
                nxt = cur;
        endcase
        return nxt;
    endfunction

    // Moves the millisecond clock on, sometimes jumping toward the next
    // button change so that long holds do not take thousands of polls.
    task automatic advance_clock();
        logic [31:0] ahead;
        ahead = btn_next_ms - clock_ms;
        if (!ahead[31] && ahead > 32'd8 && $urandom_range(0, 5) == 0)
            clock_ms = clock_ms + $urandom_range(1, ahead);
        else
            clock_ms = clock_ms + $urandom_range(0, 3);
    endtask

    // Button script: presses of glitch, short and long length with contact
    // bounce right after each change.
    task automatic next_button(output logic level);
        logic [31:0] ahead;
        logic [31:0] since;
        int          span;
        ahead = btn_next_ms - clock_ms;
        if (ahead[31] || ahead == 32'd0)
        begin
            btn_drive = ~btn_drive;
            btn_last_ms = clock_ms;
            if (btn_drive == BTN_RELEASED)
                span = $urandom_range(1, 2 * int'(reg_debounce_ms) + 20);
            else
                case ($urandom_range(0, 3))
                    0:       span = $urandom_range(0, int'(reg_debounce_ms));
                    3:       span = int'(reg_debounce_ms) + int'(reg_long_ms)
                                    + $urandom_range(1, 80);
                    default: span = int'(reg_debounce_ms) + $urandom_range(1, int'(reg_long_ms));
                endcase
            btn_next_ms = clock_ms + 32'(span);
        end
        since = clock_ms - btn_last_ms;
        level = btn_drive;
        if (since < 32'd4 && $urandom_range(0, 2) == 0)
            level = ~btn_drive;
    endtask

    // Realistic encoder turns and button presses, with a share of noise items
    // whose every field is random.
    task automatic run_traffic(input int count, input int noise_pct);
        logic       level;
        logic [1:0] pins;
        int         pick;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                send_item(1'($urandom), 2'($urandom), 1'($urandom), 32'($urandom));
            end
            else
            begin
                advance_clock();
                if ($urandom_range(0, 99) < 55)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 6)
                        pins = turn_pins(walk_pins, TURN_JUMP);
                    else if (pick < 10)
                        pins = turn_pins(walk_pins, TURN_HOLD);
                    else
                    begin
                        if (pick < 20)
                            walk_cw = ~walk_cw;
                        pins = turn_pins(walk_pins, walk_cw ? TURN_CW : TURN_CCW);
                    end
                    send_item(qebi_pkg::OP_EDGE, pins, 1'($urandom), clock_ms);
                end
                else
                begin
                    next_button(level);
                    send_item(qebi_pkg::OP_POLL, 2'($urandom), level, clock_ms);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, both item kinds, detents both ways, illegal jumps, and
    // short and long presses under the reset settings.
    task automatic test_directed_cases();
        tx_mode = TX_STEADY;
        rx_mode = RX_ALWAYS;
        send_item(qebi_pkg::OP_POLL, 2'b00, BTN_RELEASED, 32'd0);
        // Unchanged pins on an edge; the button and time fields are ignored.
        send_item(qebi_pkg::OP_EDGE, qebi_pkg::PINS_IDLE, BTN_PRESSED, 32'hFFFF_FFFF);
        // One full clockwise cycle gives two detents at two steps per detent.
        send_item(qebi_pkg::OP_EDGE, 2'b10, BTN_PRESSED, 32'd0);
        send_item(qebi_pkg::OP_EDGE, 2'b00, BTN_RELEASED, 32'd0);
        send_item(qebi_pkg::OP_EDGE, 2'b01, BTN_PRESSED, 32'hFFFF_FFFF);
        send_item(qebi_pkg::OP_EDGE, 2'b11, BTN_RELEASED, 32'd7);
        // And back counter-clockwise.
        send_item(qebi_pkg::OP_EDGE, 2'b01, BTN_RELEASED, 32'd0);
        send_item(qebi_pkg::OP_EDGE, 2'b00, BTN_RELEASED, 32'd0);
        send_item(qebi_pkg::OP_EDGE, 2'b10, BTN_RELEASED, 32'd0);
        send_item(qebi_pkg::OP_EDGE, 2'b11, BTN_RELEASED, 32'd0);
        // Illegal jump over both pins clears a half-made detent.
        send_item(qebi_pkg::OP_EDGE, 2'b10, BTN_RELEASED, 32'd0);
        send_item(qebi_pkg::OP_EDGE, 2'b01, BTN_RELEASED, 32'd0);
        send_item(qebi_pkg::OP_EDGE, 2'b11, BTN_RELEASED, 32'd0);
        send_item(qebi_pkg::OP_EDGE, 2'b00, BTN_RELEASED, 32'd0);
        // A poll picks up both pending detent events; pins are ignored.
        send_item(qebi_pkg::OP_POLL, 2'b11, BTN_RELEASED, 32'd10);
        // Short press: press, settle, release, settle.
        send_item(qebi_pkg::OP_POLL, 2'b10, BTN_PRESSED, 32'd20);
        send_item(qebi_pkg::OP_POLL, 2'b01, BTN_PRESSED, 32'd25);
        send_item(qebi_pkg::OP_POLL, 2'b00, BTN_RELEASED, 32'd200);
        send_item(qebi_pkg::OP_POLL, 2'b00, BTN_RELEASED, 32'd205);
        // Long press, then a release that reports no short press.
        send_item(qebi_pkg::OP_POLL, 2'b00, BTN_PRESSED, 32'd300);
        send_item(qebi_pkg::OP_POLL, 2'b00, BTN_PRESSED, 32'd305);
        send_item(qebi_pkg::OP_POLL, 2'b00, BTN_PRESSED, 32'd805);
        send_item(qebi_pkg::OP_POLL, 2'b00, BTN_RELEASED, 32'd900);
        send_item(qebi_pkg::OP_POLL, 2'b00, BTN_RELEASED, 32'd905);
        send_item(qebi_pkg::OP_POLL, 2'b11, BTN_PRESSED, 32'hFFFF_FFFF);
        clock_ms = 32'd1000;
        btn_next_ms = 32'd1010;
        settle();
    endtask

    task automatic test_default_traffic();
        tx_mode = TX_BURSTY;
        rx_mode = RX_PATTERN;
        run_traffic(150, 10);
        settle();
    endtask

    // Register extremes, including a threshold of zero, with varied idling;
    // the first setting runs both streams with no idle cycles at all.
    task automatic test_register_extremes();
        write_reg(REG_UNUSED, 16'hFFFF);
        apply_settings(0, 0, 1);
        tx_mode = TX_STEADY;
        rx_mode = RX_ALWAYS;
        run_traffic(230, 10);
        apply_settings(255, 65535, 3);
        tx_mode = TX_BURSTY;
        rx_mode = RX_PATTERN;
        run_traffic(230, 10);
        apply_settings(0, 65535, 0);
        rx_mode = RX_RANDOM;
        run_traffic(230, 10);
        apply_settings(255, 0, 2);
        tx_mode = TX_STEADY;
        rx_mode = RX_PATTERN;
        run_traffic(230, 10);
        apply_settings(17, 300, 1);
        tx_mode = TX_BURSTY;
        rx_mode = RX_RANDOM;
        run_traffic(230, 10);
        apply_settings(5, 500, 2);
    endtask

    // The receiver holds off while items keep coming, so the block fills up
    // and stalls its input; then the sender waits for every result.
    task automatic test_output_backpressure();
        settle();
        tx_mode = TX_STEADY;
        rx_mode = RX_ALWAYS;
        rx_hold_req = 120;
        run_traffic(40, 0);
        settle();
    endtask

    // Timestamps run across the 32-bit wrap during presses.
    task automatic test_timestamp_wrap();
        clock_ms = 32'hFFFF_FF00;
        btn_next_ms = clock_ms + 32'd3;
        tx_mode = TX_BURSTY;
        rx_mode = RX_RANDOM;
        run_traffic(200, 5);
        settle();
    endtask

    task automatic test_noise();
        tx_mode = TX_BURSTY;
        rx_mode = RX_PATTERN;
        run_traffic(300, 60);
        settle();
    endtask

    initial
    begin
        reset_predictor();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_default_traffic();
        test_register_extremes();
        test_output_backpressure();
        test_timestamp_wrap();
        test_noise();

        settle();
        repeat (8) @(posedge clk);
        $display("Checked %0d results: %0d edge and %0d poll transfers, %0d register writes.",
                 results_seen, edges_in, polls_in, reg_writes);
        $display("Saw %0d cw, %0d ccw detents, %0d short, %0d long presses, hold of %0d cycles.",
                 cw_seen, ccw_seen, short_seen, long_seen, longest_hold);
        if (mismatches == 0)
            $display("quadrature_encoder_button_input: match");
        else
            $display("quadrature_encoder_button_input: mismatch");
        $finish;
    end

endmodule
